FILE: rtl/core/brfo_pkg.sv
// ============================================================================
// Byte ring FIFO package
// Shared types, codes and default sizes for the byte ring FIFO with overwrite.
// ============================================================================
`default_nettype none

package brfo_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEPTH_DEFAULT   = 256;
    localparam int MAX_GET_DEFAULT = 64;

    // Fixed field widths.
    localparam int LEN_W  = 16;
    localparam int DATA_W = 8;
    localparam int FILL_W = 9;
    localparam int STAT_W = 2;
    localparam int OP_W   = 2;

    // Request kinds.
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_ZERO_LEN = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_GET_RD   = 2'd1,
        S_GET_EMIT = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic item;   // a request is accepted this cycle
        logic rd;     // read one stored byte and advance the read side
        logic emit;   // load the fetched byte into the output register
        logic last;   // the emitted byte ends the get
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic get_go;    // the presented request is a get that will be served
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/brfo_ctrl.sv
// ============================================================================
// Byte ring FIFO controller
// Request acceptance and the read sequence of a get.
// ============================================================================
`default_nettype none

module brfo_ctrl
    import brfo_pkg::*;
#(
    parameter int MAX_GET = MAX_GET_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [LEN_W-1:0] get_len,
    input  wire dp_stat_t         stat,
    output ctrl_cmd_t             cmd
);

    localparam int REM_W = $clog2(MAX_GET + 1);

    state_t           state_reg, state_next;
    logic [REM_W-1:0] remain_reg, remain_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        remain_next = remain_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free) begin
                    cmd.item = 1'b1;
                    if (stat.get_go) begin
                        // The length was checked against MAX_GET, so it fits.
                        remain_next = get_len[REM_W-1:0];
                        state_next  = S_GET_RD;
                    end
                end
            end
            S_GET_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_GET_EMIT;
            end
            S_GET_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.last    = (remain_reg == REM_W'(1));
                    remain_next = remain_reg - REM_W'(1);
                    state_next  = (remain_reg == REM_W'(1)) ? S_IDLE : S_GET_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/brfo_dp.sv
// ============================================================================
// Byte ring FIFO datapath
// Byte store, ring pointers, fill count, burst state and output register.
// ============================================================================
`default_nettype none

module brfo_dp
    import brfo_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int MAX_GET = MAX_GET_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic              burst_first,
    input  wire logic [LEN_W-1:0]  burst_len,
    input  wire logic [DATA_W-1:0] data_in,
    input  wire ctrl_cmd_t         cmd,
    output dp_stat_t               stat,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [STAT_W-1:0]      m_status,
    output logic [DATA_W-1:0]      m_data,
    output logic                   m_last,
    output logic [FILL_W-1:0]      m_fill
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rejected_reg, rejected_next;
    logic              overwrite_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic [FILL_W-1:0] out_fill_reg, out_fill_next;

    logic              mem_we;
    logic              full;
    logic              no_room;
    logic              get_short;
    logic              do_store;
    status_t           item_status;
    logic [CNT_W+FILL_W-1:0] fill_wide;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign no_room   = (SUM_W'(count_reg) + SUM_W'(burst_len)) > SUM_W'(DEPTH);
    assign get_short = (burst_len > LEN_W'(MAX_GET)) ||
                       (SUM_W'(burst_len) > SUM_W'(count_reg));

    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.get_go   = (opcode_t'(opcode) == OP_GET) &&
                           (burst_len != '0) && !get_short;

    // Request decode: pointer, count and burst updates plus the single result.
    always_comb begin
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        count_next    = count_reg;
        rejected_next = rejected_reg;
        item_status   = ST_OK;
        do_store      = 1'b0;
        mem_we        = 1'b0;

        if (cmd.item) begin
            case (opcode_t'(opcode))
                OP_PUT: begin
                    if (burst_first) begin
                        if (burst_len == '0) begin
                            rejected_next = 1'b1;
                            item_status   = ST_ZERO_LEN;
                        end else if (!overwrite_reg && no_room) begin
                            rejected_next = 1'b1;
                            item_status   = ST_REJECT;
                        end else begin
                            rejected_next = 1'b0;
                            do_store      = 1'b1;
                        end
                    end else if (rejected_reg) begin
                        item_status = ST_REJECT;
                    end else begin
                        do_store = 1'b1;
                    end
                    if (do_store) begin
                        if (full && !overwrite_reg) begin
                            item_status = ST_REJECT;
                        end else begin
                            mem_we      = 1'b1;
                            wr_idx_next = advance(wr_idx_reg);
                            if (full) begin
                                rd_idx_next = advance(rd_idx_reg);
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                OP_GET: begin
                    if (burst_len == '0) begin
                        item_status = ST_ZERO_LEN;
                    end else if (get_short) begin
                        item_status = ST_REJECT;
                    end
                end
                OP_CLEAR: begin
                    rd_idx_next   = '0;
                    wr_idx_next   = '0;
                    count_next    = '0;
                    rejected_next = 1'b0;
                end
                default: begin
                    item_status = ST_OK;
                end
            endcase
        end else if (cmd.rd) begin
            rd_idx_next = advance(rd_idx_reg);
            count_next  = count_reg - CNT_W'(1);
        end
    end

    assign fill_wide = {{FILL_W{1'b0}}, count_next};

    // Output register loading.
    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_fill_next   = out_fill_reg;
        if (cmd.item && !stat.get_go) begin
            out_valid_next  = 1'b1;
            out_status_next = item_status;
            out_data_next   = '0;
            out_last_next   = 1'b1;
            out_fill_next   = fill_wide[FILL_W-1:0];
        end else if (cmd.emit) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_data_next   = rd_data_reg;
            out_last_next   = cmd.last;
            out_fill_next   = fill_wide[FILL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            rejected_reg  <= 1'b0;
            overwrite_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            count_reg     <= count_next;
            rejected_reg  <= rejected_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                overwrite_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_fill_reg   <= out_fill_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx_reg] <= data_in;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_data   = out_data_reg;
    assign m_last   = out_last_reg;
    assign m_fill   = out_fill_reg;

endmodule

`default_nettype wire

FILE: rtl/core/byte_ring_fifo_overwrite_top.sv
// ============================================================================
// Byte ring FIFO with overwrite
// Top level: stream ports, configuration register port, controller and datapath.
// ============================================================================
// This block is a byte ring FIFO of DEPTH entries driven by one request
// stream. A put request carries one byte; the first byte of a burst carries
// the burst length, and when overwrite is off a burst that does not fit in
// the free space is rejected whole, its later bytes answered with a reject
// status. With overwrite on, a byte that arrives while the store is full
// evicts the oldest byte. A get request asks for 1 to MAX_GET bytes and
// returns either that many bytes, the final one marked with m_tlast, or a
// single failure result. A clear request empties the FIFO. Every result
// reports the fill count after it. Put, clear and failed get requests each
// give one result, so they stream at one per cycle while the result side
// keeps up. A served get of N bytes holds the input until its last byte is
// loaded: each byte is first read from the store through its registered
// read port and then loaded into the output register, and that load waits
// while the result side stalls. The result register holds one result, so a
// new request is taken in the cycle in which the earlier result leaves, but
// not while that result is held by a stall. The overwrite_enable register
// is written through cfg_wr_en and cfg_wr_data and should only change while
// the block is idle.
`default_nettype none

module byte_ring_fifo_overwrite_top
    import brfo_pkg::*;
#(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int MAX_GET = MAX_GET_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration: overwrite_enable.
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,

    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] burst_len, [23:16] data_in
    input  wire logic [2:0]  s_tuser,   // [1:0] opcode, [2] burst_first

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] data_out, [16:8] fill_count, [23:17] zero
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast
);

    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic [LEN_W-1:0]  burst_len;
    logic [DATA_W-1:0] data_in;
    logic [OP_W-1:0]   opcode;
    logic              burst_first;
    logic [DATA_W-1:0] data_out;
    logic [FILL_W-1:0] fill_count;

    // Unpack the request fields.
    assign burst_len   = s_tdata[15:0];
    assign data_in     = s_tdata[23:16];
    assign opcode      = s_tuser[1:0];
    assign burst_first = s_tuser[2];

    // The controller owns acceptance and sequences the bytes of a get.
    brfo_ctrl #(
        .MAX_GET (MAX_GET)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .get_len  (burst_len),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the store, the pointers, the count and the result.
    brfo_dp #(
        .DEPTH   (DEPTH),
        .MAX_GET (MAX_GET)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .burst_first (burst_first),
        .burst_len   (burst_len),
        .data_in     (data_in),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_status    (m_tuser),
        .m_data      (data_out),
        .m_last      (m_tlast),
        .m_fill      (fill_count)
    );

    // Pack the result fields, padded with zeros to whole bytes.
    assign m_tdata = {7'd0, fill_count, data_out};

endmodule

`default_nettype wire
